// ----- hw/rtl/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg: shared definitions of the max-heap priority queue
// Sizes, request and response payloads, result codes, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int HEAP_DEPTH = 64;
	localparam int KEY_W      = 32;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
	// wide enough to hold a left or right child index of any entry
	localparam int IDX_W      = CNT_W + 1;

	// request operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// result status codes
	localparam logic [1:0] RES_DONE  = 2'd0;
	localparam logic [1:0] RES_FULL  = 2'd1;
	localparam logic [1:0] RES_EMPTY = 2'd2;

	typedef struct packed {
		logic                    operation;
		logic signed [KEY_W-1:0] key_in;
	} req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] removed_key;
		logic signed [KEY_W-1:0] top_key;
		logic        [CNT_W-1:0] entry_count;
		logic        [1:0]       status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_LOAD,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		RD_PARENT,
		RD_LAST,
		RD_LEFT,
		RD_RIGHT
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    in_ready;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_key;
		logic    wr_move;
		logic    wr_child;
		logic    cap_left;
		logic    load_last;
		logic    finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_valid;
		logic req_pop;
		logic full;
		logic empty;
		logic pos_zero;
		logic up_go;
		logic dn_leaf;
		logic dn_go;
		logic right_ok;
		logic out_busy;
	} stat_t;

endpackage

// ----- hw/rtl/mhpq_req_if.sv -----
// ----------------------------------------------------------------------------
// mhpq_req_if: request channel
// Valid/ready channel that carries one push or pop request.
// ----------------------------------------------------------------------------
interface mhpq_req_if;
	logic               valid;
	logic               ready;
	mhpq_pkg::req_t     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/mhpq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mhpq_rsp_if: response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface mhpq_rsp_if;
	logic               valid;
	logic               ready;
	mhpq_pkg::rsp_t     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/max_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// max_heap_priority_queue: binary max-heap of signed 32-bit keys
// Push sifts a key up, pop removes the root and sifts the last entry down.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                         transfer
//   req      in   operation, key_in                               valid & ready
//   rsp      out  removed_key, top_key, entry_count, status       valid & ready
//
// Requests are handled one at a time. A push moves its key up at most 6 levels
// and a pop moves the last entry down at most 5 levels at 64 entries; each level
// is read through the single read port of the heap RAM with its registered
// data, and a refused request goes straight to its result.
// Reset empties the heap at once; the RAM needs no clearing pass.
// A new request is taken while a result waits; a stalled response holds the
// next result in the controller until the output register frees up.
// ----------------------------------------------------------------------------
module max_heap_priority_queue (
	input  logic       clk,
	input  logic       arst_n,
	mhpq_req_if.sink   req,
	mhpq_rsp_if.source rsp
);

	mhpq_pkg::cmd_t  cmd;
	mhpq_pkg::stat_t st;

	mhpq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	mhpq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.st     (st)
	);

	// an empty heap reports a zero top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.entry_count == '0 |-> rsp.payload.top_key == '0)
		else $error("empty heap reports a nonzero top key");

	// a refused pop changes nothing and removes nothing
	a_refused_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.payload.status == mhpq_pkg::RES_EMPTY |->
		rsp.payload.removed_key == '0 && rsp.payload.entry_count == '0)
		else $error("refused pop reports a key or a count");

	// occupancy stays within the heap depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.payload.entry_count <= mhpq_pkg::CNT_W'(mhpq_pkg::HEAP_DEPTH))
		else $error("entry count beyond heap depth");

	// one request at a time: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a request is in flight");

endmodule

// ----- hw/rtl/mhpq_ram.sv -----
// ----------------------------------------------------------------------------
// mhpq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/mhpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mhpq_ctrl: heap controller
// Sequences accept, sift-up, sift-down and result hand-off.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  mhpq_pkg::stat_t st,
	output mhpq_pkg::cmd_t  cmd
);

	mhpq_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mhpq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = mhpq_pkg::RD_PARENT;
		case (state_q)
			mhpq_pkg::S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.req_valid) begin
					if (st.req_pop) begin
						state_d = st.empty ? mhpq_pkg::S_FIN : mhpq_pkg::S_DN_LAST;
					end else begin
						state_d = st.full ? mhpq_pkg::S_FIN : mhpq_pkg::S_UP_RD;
					end
				end
			end
			// fetch the parent, or settle at the root
			mhpq_pkg::S_UP_RD: begin
				if (st.pos_zero) begin
					cmd.wr_key = 1'b1;
					state_d    = mhpq_pkg::S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = mhpq_pkg::RD_PARENT;
					state_d    = mhpq_pkg::S_UP_CMP;
				end
			end
			// move the parent down or drop the key in place
			mhpq_pkg::S_UP_CMP: begin
				if (st.up_go) begin
					cmd.wr_move = 1'b1;
					state_d     = mhpq_pkg::S_UP_RD;
				end else begin
					cmd.wr_key = 1'b1;
					state_d    = mhpq_pkg::S_FIN;
				end
			end
			mhpq_pkg::S_DN_LAST: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = mhpq_pkg::RD_LAST;
				state_d    = mhpq_pkg::S_DN_LOAD;
			end
			mhpq_pkg::S_DN_LOAD: begin
				cmd.load_last = 1'b1;
				state_d       = mhpq_pkg::S_DN_RDL;
			end
			// fetch the left child, or settle at a leaf
			mhpq_pkg::S_DN_RDL: begin
				if (st.dn_leaf) begin
					cmd.wr_key = 1'b1;
					state_d    = mhpq_pkg::S_FIN;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = mhpq_pkg::RD_LEFT;
					state_d    = mhpq_pkg::S_DN_RDR;
				end
			end
			mhpq_pkg::S_DN_RDR: begin
				cmd.cap_left = 1'b1;
				cmd.rd_en    = st.right_ok;
				cmd.rd_sel   = mhpq_pkg::RD_RIGHT;
				state_d      = mhpq_pkg::S_DN_CMP;
			end
			// move the chosen child up or drop the key in place
			mhpq_pkg::S_DN_CMP: begin
				if (st.dn_go) begin
					cmd.wr_child = 1'b1;
					state_d      = mhpq_pkg::S_DN_RDL;
				end else begin
					cmd.wr_key = 1'b1;
					state_d    = mhpq_pkg::S_FIN;
				end
			end
			// hold until the output register is free
			mhpq_pkg::S_FIN: begin
				if (!st.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = mhpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mhpq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/mhpq_dp.sv -----
// ----------------------------------------------------------------------------
// mhpq_dp: heap datapath
// Heap RAM, moving key, hole position, count, root copy and result register.
// ----------------------------------------------------------------------------
module mhpq_dp (
	input  logic             clk,
	input  logic             arst_n,
	mhpq_req_if.sink         req,
	mhpq_rsp_if.source       rsp,
	input  mhpq_pkg::cmd_t   cmd,
	output mhpq_pkg::stat_t  st
);

	localparam int AW = mhpq_pkg::ADDR_W;
	localparam int CW = mhpq_pkg::CNT_W;
	localparam int IW = mhpq_pkg::IDX_W;
	localparam int KW = mhpq_pkg::KEY_W;

	logic                 start;
	logic signed [KW-1:0] key_q, left_q, root_q, removed_q;
	logic        [AW-1:0] pos_q;
	logic        [CW-1:0] count_q;
	logic        [1:0]    status_q;
	logic                 out_valid_q;
	mhpq_pkg::rsp_t       out_q;

	logic        [IW-1:0] pos_ext, cnt_ext, left_w, right_w;
	logic        [AW-1:0] parent, rd_addr, wr_addr;
	logic                 take_right, wr_en;
	logic signed [KW-1:0] rd_key, child, wr_data;
	logic        [KW-1:0] rd_raw;
	logic        [AW-1:0] pick;

	assign start     = cmd.in_ready && req.valid;
	assign req.ready = cmd.in_ready;

	// index arithmetic of the hole
	assign pos_ext = {{(IW - AW){1'b0}}, pos_q};
	assign cnt_ext = {{(IW - CW){1'b0}}, count_q};
	assign left_w  = (pos_ext << 1) | IW'(1);
	assign right_w = left_w + IW'(1);
	assign parent  = (pos_q - AW'(1)) >> 1;

	// choose the child: left only if strictly greater than right
	assign rd_key     = $signed(rd_raw);
	assign take_right = st.right_ok && !(rd_key < left_q);
	assign child      = take_right ? rd_key : left_q;
	assign pick       = take_right ? right_w[AW-1:0] : left_w[AW-1:0];

	// status toward the controller
	assign st.req_valid = req.valid;
	assign st.req_pop   = (req.payload.operation == mhpq_pkg::OP_POP);
	assign st.full      = (count_q >= CW'(mhpq_pkg::HEAP_DEPTH));
	assign st.empty     = (count_q == '0);
	assign st.pos_zero  = (pos_q == '0);
	assign st.up_go     = (rd_key < key_q);
	assign st.dn_leaf   = (left_w >= cnt_ext);
	assign st.right_ok  = (right_w < cnt_ext);
	assign st.dn_go     = (key_q < child);
	assign st.out_busy  = out_valid_q && !rsp.ready;

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			mhpq_pkg::RD_PARENT: rd_addr = parent;
			mhpq_pkg::RD_LAST:   rd_addr = count_q[AW-1:0];
			mhpq_pkg::RD_LEFT:   rd_addr = left_w[AW-1:0];
			mhpq_pkg::RD_RIGHT:  rd_addr = right_w[AW-1:0];
			default:             rd_addr = parent;
		endcase
	end

	// write port: all writes land at the hole
	assign wr_en   = cmd.wr_key || cmd.wr_move || cmd.wr_child;
	assign wr_addr = pos_q;
	always_comb begin
		if (cmd.wr_move) begin
			wr_data = rd_key;
		end else if (cmd.wr_child) begin
			wr_data = child;
		end else begin
			wr_data = key_q;
		end
	end

	mhpq_ram #(
		.WIDTH (KW),
		.DEPTH (mhpq_pkg::HEAP_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			if (req.payload.operation == mhpq_pkg::OP_POP) begin
				if (!st.empty) begin
					count_q <= count_q - CW'(1);
				end
			end else if (!st.full) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// capture the request, then track the moving key and the hole
	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= req.payload.key_in;
			if (req.payload.operation == mhpq_pkg::OP_POP) begin
				pos_q <= '0;
				if (st.empty) begin
					removed_q <= '0;
					status_q  <= mhpq_pkg::RES_EMPTY;
				end else begin
					removed_q <= root_q;
					status_q  <= mhpq_pkg::RES_DONE;
				end
			end else begin
				pos_q     <= count_q[AW-1:0];
				removed_q <= '0;
				status_q  <= st.full ? mhpq_pkg::RES_FULL : mhpq_pkg::RES_DONE;
			end
		end
		if (cmd.load_last) begin
			key_q <= rd_key;
		end
		if (cmd.cap_left) begin
			left_q <= rd_key;
		end
		if (cmd.wr_move) begin
			pos_q <= parent;
		end
		if (cmd.wr_child) begin
			pos_q <= pick;
		end
		// mirror entry zero for the top and removed keys
		if (wr_en && wr_addr == '0) begin
			root_q <= wr_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.removed_key <= removed_q;
			out_q.top_key     <= (count_q != '0) ? root_q : '0;
			out_q.entry_count <= count_q;
			out_q.status      <= status_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the max-heap priority queue
// Drives push and pop requests through the request channel and checks every
// response against a heap kept inside the bench, field by field. Directed
// extremes come first, then random fill, drain, mixed and noise sequences,
// with random idle bursts on both channels and one long response stall.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_ITEMS  = 1600;
	localparam int TAIL_ITEMS    = 150;
	localparam int IDLE_STRETCH  = 150;
	localparam int HOLD_AFTER    = 300;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 40;
	localparam int WATCHDOG_NS   = 6_000_000;

	typedef enum {EP_FILL, EP_DRAIN, EP_NOISE, EP_MIX} episode_t;

	logic clk;
	logic arst_n;

	mhpq_req_if req_ch ();
	mhpq_rsp_if rsp_ch ();

	max_heap_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// requests waiting to be offered, and responses owed by the block
	mhpq_pkg::req_t request_q [$];
	mhpq_pkg::rsp_t due_results [$];

	// heap mirror
	logic signed [mhpq_pkg::KEY_W-1:0] heap_keys [mhpq_pkg::HEAP_DEPTH];
	int heap_size = 0;

	// fill level tracked while the request list is built
	int gen_level = 0;

	int   total_items = 0;
	int   sent_count  = 0;
	int   recv_count  = 0;
	int   send_gap    = 0;
	int   recv_gap    = 0;
	int   fail_count  = 0;
	logic rsp_hold    = 1'b0;

	// clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// apply one request to the heap mirror and return the response it owes
	function automatic mhpq_pkg::rsp_t heap_step(mhpq_pkg::req_t r);
		mhpq_pkg::rsp_t res;
		int pos, up, left, pick;
		logic signed [mhpq_pkg::KEY_W-1:0] t;
		res = '0;
		res.status = mhpq_pkg::RES_DONE;
		if (r.operation == mhpq_pkg::OP_PUSH) begin
			if (heap_size >= mhpq_pkg::HEAP_DEPTH) begin
				res.status = mhpq_pkg::RES_FULL;
			end else begin
				// append and sift up while the parent is strictly smaller
				heap_keys[heap_size] = r.key_in;
				pos = heap_size;
				heap_size++;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (!(heap_keys[up] < heap_keys[pos]))
						break;
					t = heap_keys[up];
					heap_keys[up] = heap_keys[pos];
					heap_keys[pos] = t;
					pos = up;
				end
			end
		end else if (heap_size == 0) begin
			res.status = mhpq_pkg::RES_EMPTY;
		end else begin
			// take the root, move the last entry up and sift it down
			res.removed_key = heap_keys[0];
			heap_size--;
			heap_keys[0] = heap_keys[heap_size];
			pos = 0;
			while (2 * pos + 1 < heap_size) begin
				left = 2 * pos + 1;
				// equal children go right
				if (left + 1 >= heap_size || heap_keys[left + 1] < heap_keys[left])
					pick = left;
				else
					pick = left + 1;
				if (!(heap_keys[pos] < heap_keys[pick]))
					break;
				t = heap_keys[pos];
				heap_keys[pos] = heap_keys[pick];
				heap_keys[pick] = t;
				pos = pick;
			end
		end
		res.top_key = (heap_size > 0) ? heap_keys[0] : '0;
		res.entry_count = mhpq_pkg::CNT_W'(heap_size);
		return res;
	endfunction

	function automatic void add_request(logic op, logic signed [mhpq_pkg::KEY_W-1:0] key);
		mhpq_pkg::req_t r;
		r.operation = op;
		r.key_in = key;
		request_q.push_back(r);
		if (op == mhpq_pkg::OP_PUSH && gen_level < mhpq_pkg::HEAP_DEPTH)
			gen_level++;
		else if (op == mhpq_pkg::OP_POP && gen_level > 0)
			gen_level--;
	endfunction

	// favor extremes and a narrow band of repeated keys
	function automatic logic signed [mhpq_pkg::KEY_W-1:0] pick_key();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return int'($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	// request driver: hold valid until the transfer, then idle or offer the next
	always @(posedge clk or negedge arst_n) begin : driver
		logic next_valid;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= '0;
			send_gap = 0;
		end else begin
			next_valid = req_ch.valid;
			if (req_ch.valid && req_ch.ready) begin
				due_results.push_back(heap_step(request_q.pop_front()));
				sent_count++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (request_q.size() == 0) begin
					next_valid = 1'b0;
				end else if (!rsp_hold && sent_count + TAIL_ITEMS < total_items
						&& (sent_count / IDLE_STRETCH) % 3 != 2
						&& $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(1, 14) - 1;
				end else begin
					next_valid = 1'b1;
					req_ch.payload <= request_q[0];
				end
			end
			req_ch.valid <= next_valid;
		end
	end

	// response monitor: check each transfer, then pick the next ready level
	always @(posedge clk or negedge arst_n) begin : monitor
		mhpq_pkg::rsp_t want;
		mhpq_pkg::rsp_t got;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.payload;
				recv_count++;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected response: removed %0d top %0d",
						$time, got.removed_key, got.top_key);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (got.removed_key !== want.removed_key) begin
						$display("%0t: removed_key expected %0d, actual %0d",
							$time, want.removed_key, got.removed_key);
						fail_count++;
					end
					if (got.top_key !== want.top_key) begin
						$display("%0t: top_key expected %0d, actual %0d",
							$time, want.top_key, got.top_key);
						fail_count++;
					end
					if (got.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d, actual %0d",
							$time, want.entry_count, got.entry_count);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, got.status);
						fail_count++;
					end
				end
			end
			if (rsp_hold) begin
				rsp_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else if (recv_count + TAIL_ITEMS < total_items
					&& (recv_count / IDLE_STRETCH) % 3 != 2
					&& $urandom_range(0, 5) == 0) begin
				recv_gap = $urandom_range(1, 14) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// stall the response side long enough to back up the request side
	initial begin
		while (sent_count < HOLD_AFTER)
			@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES)
			@(posedge clk);
		rsp_hold <= 1'b0;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("CHECK FAILED");
		$finish;
	end

	// build the request list, run reset, wait for the last response, report
	initial begin : stimulus
		episode_t kind;
		int n, push_pct, ep;
		arst_n = 1'b0;

		// directed: pop from empty, extremes, equal keys, drain past empty
		add_request(mhpq_pkg::OP_POP, -1);
		add_request(mhpq_pkg::OP_PUSH, 32'sh7FFF_FFFF);
		add_request(mhpq_pkg::OP_PUSH, 32'sh8000_0000);
		add_request(mhpq_pkg::OP_PUSH, 0);
		add_request(mhpq_pkg::OP_PUSH, -1);
		add_request(mhpq_pkg::OP_PUSH, 7);
		add_request(mhpq_pkg::OP_PUSH, 7);
		add_request(mhpq_pkg::OP_PUSH, 7);
		add_request(mhpq_pkg::OP_PUSH, 1);
		add_request(mhpq_pkg::OP_PUSH, 7);
		repeat (10)
			add_request(mhpq_pkg::OP_POP, -1);
		total_items = request_q.size() + RANDOM_ITEMS;

		// random: start with a fill to the top, then mixed sequences
		for (ep = 0; request_q.size() < total_items; ep++) begin
			case ($urandom_range(0, 9))
				0: kind = EP_FILL;
				1: kind = EP_DRAIN;
				2: kind = EP_NOISE;
				default: kind = EP_MIX;
			endcase
			if (ep == 0)
				kind = EP_FILL;
			case (kind)
				EP_FILL: begin
					while (gen_level < mhpq_pkg::HEAP_DEPTH)
						add_request(mhpq_pkg::OP_PUSH, pick_key());
					repeat ($urandom_range(1, 3))
						add_request(mhpq_pkg::OP_PUSH, pick_key());
				end
				EP_DRAIN: begin
					while (gen_level > 0)
						add_request(mhpq_pkg::OP_POP, $urandom);
					repeat ($urandom_range(1, 3))
						add_request(mhpq_pkg::OP_POP, $urandom);
				end
				EP_NOISE: begin
					repeat ($urandom_range(5, 20))
						add_request($urandom_range(0, 1) == 1 ? mhpq_pkg::OP_POP
							: mhpq_pkg::OP_PUSH, $urandom);
				end
				default: begin
					n = $urandom_range(10, 60);
					repeat (n) begin
						if (gen_level < 8)
							push_pct = 75;
						else if (gen_level > mhpq_pkg::HEAP_DEPTH - 8)
							push_pct = 30;
						else
							push_pct = 55;
						if ($urandom_range(1, 100) <= push_pct)
							add_request(mhpq_pkg::OP_PUSH, pick_key());
						else
							add_request(mhpq_pkg::OP_POP, $urandom);
					end
				end
			endcase
		end
		total_items = request_q.size();

		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_q.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- max_heap_priority_queue.f -----
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_req_if.sv
hw/rtl/mhpq_rsp_if.sv
hw/rtl/mhpq_ram.sv
hw/rtl/mhpq_ctrl.sv
hw/rtl/mhpq_dp.sv
hw/rtl/max_heap_priority_queue.sv
tb/tb_top.sv
